// ===== sv/prl_pkg.sv =====
// Shared constants for the prefix repeat length block.
// No dependencies; imported by prefix_repeat_length_z.
package prl_pkg;

    localparam int CHAR_W = 8;
    localparam int CFG_W  = 11;
    localparam int OUT_W  = 11;
    localparam int ST_W   = 4;

    localparam logic [ST_W-1:0] S_CLR   = 4'd0;
    localparam logic [ST_W-1:0] S_LOAD  = 4'd1;
    localparam logic [ST_W-1:0] S_ZRD   = 4'd2;
    localparam logic [ST_W-1:0] S_ZINIT = 4'd3;
    localparam logic [ST_W-1:0] S_ZCMP  = 4'd4;
    localparam logic [ST_W-1:0] S_ZWR   = 4'd5;
    localparam logic [ST_W-1:0] S_HWR   = 4'd6;
    localparam logic [ST_W-1:0] S_SRD   = 4'd7;
    localparam logic [ST_W-1:0] S_SACC  = 4'd8;
    localparam logic [ST_W-1:0] S_DONE  = 4'd9;

endpackage

// ===== sv/prefix_repeat_length_z.sv =====
// Top level: longest string prefix that occurs at least min_occurrences times.
// Uses prl_pkg; holds the string/Z memory and the histogram memory.
//
//  channel | signals                           | content
//  --------+-----------------------------------+------------------------------------
//  in      | s_tvalid s_tready s_tdata s_tlast | one character, tlast ends the string
//  out     | m_tvalid m_tready m_tdata         | best length and overflow flag
//  config  | cfg_we cfg_wdata                  | min_occurrences
//
// Characters load at one per cycle while s_tready is high. After the last one, the
// Z pass reads each position, extends the match one character at a time and writes
// the Z value and, for a nonzero Z, its histogram entry; the count scan then reads
// and clears the histogram entry of each length. After reset a clearing pass sweeps
// the histogram memory with s_tready low. A stalled result holds in the output
// register while the next string loads.
module prefix_repeat_length_z
    import prl_pkg::*;
#(
    parameter int MAX_LEN = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] char_in
    input  logic              s_tlast,   // is_last
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [10:0] best_length, [11] overflow
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int CMP_W = ((LW > CFG_W) ? LW : CFG_W) + 1;

    // Entry of the string memory: character and its Z value.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [LW-1:0]     z;
    } entry_t;

    entry_t            ent_mem [MAX_LEN];
    logic [LW-1:0]     hist_mem [MAX_LEN];

    logic [ST_W-1:0]   state_reg, state_next;
    logic [LW-1:0]     len_reg, len_next;
    logic              ovf_reg, ovf_next;
    logic [LW-1:0]     n_reg, n_next;
    logic [LW-1:0]     i_reg, i_next;
    logic [LW-1:0]     l_reg, l_next;
    logic [LW-1:0]     r_reg, r_next;
    logic [LW-1:0]     z_reg, z_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic [LW-1:0]     acc_reg, acc_next;
    logic [LW-1:0]     best_reg, best_next;
    logic              found_reg, found_next;
    logic [LW-1:0]     scan_reg, scan_next;
    logic [LW-1:0]     clr_reg, clr_next;
    logic [CFG_W-1:0]  min_reg;
    logic              mval_reg, mval_next;
    logic [15:0]       mdata_reg, mdata_next;

    logic              ent_we;
    logic [AW-1:0]     ent_waddr, ent_raddr_a, ent_raddr_b;
    entry_t            ent_wdata, ent_rd_a, ent_rd_b;
    logic              hist_we;
    logic [AW-1:0]     hist_waddr, hist_raddr;
    logic [LW-1:0]     hist_wdata, hist_rd;

    logic [LW-1:0]     span, zi, zn, acc_sum;

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rd_a <= ent_mem[ent_raddr_a];
        ent_rd_b <= ent_mem[ent_raddr_b];
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rd <= hist_mem[hist_raddr];
    end

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        z_next      = z_reg;
        ch_next     = ch_reg;
        acc_next    = acc_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        scan_next   = scan_reg;
        clr_next    = clr_reg;
        mval_next   = mval_reg && !m_tready;
        mdata_next  = mdata_reg;
        ent_we      = 1'b0;
        ent_waddr   = len_reg[AW-1:0];
        ent_wdata   = '{ch: s_tdata, z: '0};
        ent_raddr_a = i_reg[AW-1:0];
        ent_raddr_b = AW'(i_reg - l_reg);
        hist_we     = 1'b0;
        hist_waddr  = clr_reg[AW-1:0];
        hist_wdata  = '0;
        hist_raddr  = z_reg[AW-1:0];
        span        = r_reg - i_reg + LW'(1);
        zi          = '0;
        zn          = z_reg + LW'(1);
        acc_sum     = acc_reg + hist_rd;

        case (state_reg)
            S_CLR:
            begin
                hist_we  = 1'b1;
                clr_next = clr_reg + LW'(1);
                if (clr_reg == LW'(MAX_LEN - 1))
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (s_tvalid)
                begin
                    n_next = len_reg;
                    if (len_reg < LW'(MAX_LEN))
                    begin
                        ent_we   = 1'b1;
                        len_next = len_reg + LW'(1);
                        n_next   = len_reg + LW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        i_next     = LW'(1);
                        l_next     = '0;
                        r_next     = '0;
                        state_next = S_ZRD;
                    end
                end
            end
            S_ZRD:
            begin
                // Reads of entry i and of the mirrored entry i - l were issued
                // through the default addresses above.
                if (i_reg < n_reg)
                begin
                    state_next = S_ZINIT;
                end
                else
                begin
                    scan_next  = n_reg - LW'(1);
                    acc_next   = '0;
                    best_next  = (min_reg <= CFG_W'(1)) ? n_reg : '0;
                    found_next = (min_reg <= CFG_W'(1));
                    state_next = (n_reg <= LW'(1)) ? S_DONE : S_SRD;
                end
            end
            S_ZINIT:
            begin
                ch_next = ent_rd_a.ch;
                if (i_reg <= r_reg)
                begin
                    zi = (ent_rd_b.z < span) ? ent_rd_b.z : span;
                end
                z_next      = zi;
                ent_raddr_a = zi[AW-1:0];
                ent_raddr_b = AW'(i_reg + zi);
                state_next  = ((i_reg + zi) < n_reg) ? S_ZCMP : S_ZWR;
            end
            S_ZCMP:
            begin
                ent_raddr_a = zn[AW-1:0];
                ent_raddr_b = AW'(i_reg + zn);
                if (ent_rd_a.ch == ent_rd_b.ch)
                begin
                    z_next = zn;
                    if (!((i_reg + zn) < n_reg))
                    begin
                        state_next = S_ZWR;
                    end
                end
                else
                begin
                    state_next = S_ZWR;
                end
            end
            S_ZWR:
            begin
                ent_we    = 1'b1;
                ent_waddr = i_reg[AW-1:0];
                ent_wdata = '{ch: ch_reg, z: z_reg};
                if (z_reg != '0 && (i_reg + z_reg - LW'(1)) > r_reg)
                begin
                    l_next = i_reg;
                    r_next = i_reg + z_reg - LW'(1);
                end
                if (z_reg != '0)
                begin
                    state_next = S_HWR;
                end
                else
                begin
                    i_next     = i_reg + LW'(1);
                    state_next = S_ZRD;
                end
            end
            S_HWR:
            begin
                hist_we    = 1'b1;
                hist_waddr = z_reg[AW-1:0];
                hist_wdata = hist_rd + LW'(1);
                i_next     = i_reg + LW'(1);
                state_next = S_ZRD;
            end
            S_SRD:
            begin
                hist_raddr = scan_reg[AW-1:0];
                state_next = S_SACC;
            end
            S_SACC:
            begin
                // Counts accumulate from the longest length down; the
                // histogram entry is cleared for the next string on the way.
                hist_we    = 1'b1;
                hist_waddr = scan_reg[AW-1:0];
                acc_next   = acc_sum;
                if (!found_reg &&
                    (CMP_W'(acc_sum) + CMP_W'(1)) >= CMP_W'(min_reg))
                begin
                    found_next = 1'b1;
                    best_next  = scan_reg;
                end
                scan_next  = scan_reg - LW'(1);
                state_next = (scan_reg == LW'(1)) ? S_DONE : S_SRD;
            end
            S_DONE:
            begin
                if (!mval_reg || m_tready)
                begin
                    mval_next  = 1'b1;
                    mdata_next = {4'd0, ovf_reg, OUT_W'(best_reg)};
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            clr_reg   <= '0;
            min_reg   <= CFG_W'(1);
            mval_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            clr_reg   <= clr_next;
            mval_reg  <= mval_next;
            found_reg <= found_next;
            if (cfg_we)
            begin
                min_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        i_reg     <= i_next;
        l_reg     <= l_next;
        r_reg     <= r_next;
        z_reg     <= z_next;
        ch_reg    <= ch_next;
        acc_reg   <= acc_next;
        best_reg  <= best_next;
        scan_reg  <= scan_next;
        mdata_reg <= mdata_next;
    end

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_LEN))
        else $error("load count beyond buffer");

    a_cmp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ZCMP |-> (i_reg + z_reg) < n_reg)
        else $error("compare past end of string");

    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> state_reg == S_ZRD)
        else $error("last character did not start the Z pass");

    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ZRD && r_reg != '0 |-> l_reg <= r_reg && r_reg < n_reg)
        else $error("Z window out of order");

    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && state_next == S_LOAD |=> m_tvalid)
        else $error("result not presented");
`endif

endmodule
